// File: design/lscw_pkg.sv
`default_nettype none
package lscw_pkg;

  // Panel geometry
  localparam int unsigned PANEL_WIDTH  = 320;
  localparam int unsigned PANEL_HEIGHT = 240;

  localparam logic [15:0] COL_END_RST  = 16'(PANEL_WIDTH - 1);
  localparam logic [15:0] ROW_LAST_RST = 16'(PANEL_HEIGHT - 1);
  localparam logic [15:0] PANEL_W16    = 16'(PANEL_WIDTH);
  localparam logic [15:0] PANEL_H16    = 16'(PANEL_HEIGHT);

  // Command opcodes
  localparam logic [7:0] OP_SOFT_RESET   = 8'h01;
  localparam logic [7:0] OP_SLEEP_IN     = 8'h10;
  localparam logic [7:0] OP_SLEEP_OUT    = 8'h11;
  localparam logic [7:0] OP_INVERT_OFF   = 8'h20;
  localparam logic [7:0] OP_INVERT_ON    = 8'h21;
  localparam logic [7:0] OP_DISPLAY_OFF  = 8'h28;
  localparam logic [7:0] OP_DISPLAY_ON   = 8'h29;
  localparam logic [7:0] OP_COLUMN_SET   = 8'h2a;
  localparam logic [7:0] OP_ROW_SET      = 8'h2b;
  localparam logic [7:0] OP_MEMORY_WRITE = 8'h2c;
  localparam logic [7:0] OP_ACCESS_CTL   = 8'h36;
  localparam logic [7:0] OP_PIXEL_FORMAT = 8'h3a;
  localparam logic [7:0] OP_RAM_CTL      = 8'hb0;

  // Format and RAM control constants
  localparam logic [7:0] FORMAT_MASK       = 8'h77;
  localparam logic [7:0] FORMAT_16BIT      = 8'h55;
  localparam logic [7:0] COLOR_FORMAT_RST  = 8'h55;
  localparam logic [7:0] RAM_CTL_RST       = 8'hf0;
  localparam int unsigned RAMCTL_LITTLE_POS = 3;

  typedef struct packed {
    logic       is_data;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        pixel_write;
    logic [7:0]  pixel_row;
    logic [8:0]  pixel_col;
    logic [15:0] pixel_value;
    logic        clear_frame;
    logic        display_enabled;
    logic        sleep_mode;
    logic        invert_mode;
    logic [7:0]  mem_access_ctl;
    logic [7:0]  color_mode;
  } out_item_t;

  // Number of argument bytes a command collects
  function automatic logic [2:0] args_needed(input logic [7:0] op);
    logic [2:0] n;
    n = 3'd0;
    case (op)
      OP_COLUMN_SET, OP_ROW_SET:     n = 3'd4;
      OP_ACCESS_CTL, OP_PIXEL_FORMAT: n = 3'd1;
      OP_RAM_CTL:                    n = 3'd2;
      default:                       n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: design/lscw_ifs.sv
`default_nettype none
// Byte channel into the block
interface lscw_in_if;
  logic                 valid;
  logic                 ready;
  lscw_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Pixel / status channel out of the block
interface lscw_out_if;
  logic                 valid;
  logic                 ready;
  lscw_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/lscw_in_stage.sv
`default_nettype none
module lscw_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire lscw_pkg::in_item_t in_data,
  output      logic               q_valid,
  output      lscw_pkg::in_item_t q_data,
  input  wire logic               q_take
);
  import lscw_pkg::*;

  // Input register refills whenever it is empty or drained this cycle
  assign in_ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_data <= in_data;
    end
  end

endmodule
`default_nettype wire

// File: design/lscw_cmd_core.sv
`default_nettype none
module lscw_cmd_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire lscw_pkg::in_item_t  item,
  output      lscw_pkg::out_item_t result
);
  import lscw_pkg::*;

  // Architectural state
  logic [7:0]  current_command, current_command_next;
  logic [7:0]  arg_bytes [4];
  logic [7:0]  arg_bytes_next [4];
  logic [2:0]  arg_count_seen, arg_count_seen_next;
  logic        pixel_phase, pixel_phase_next;
  logic [7:0]  access_control_reg, access_control_reg_next;
  logic [7:0]  color_format_reg, color_format_reg_next;
  logic [7:0]  ram_control_reg, ram_control_reg_next;
  logic        display_on_flag, display_on_flag_next;
  logic        sleep_flag, sleep_flag_next;
  logic        invert_flag, invert_flag_next;
  logic [15:0] cur_column, cur_column_next;
  logic [15:0] cur_row, cur_row_next;
  logic [15:0] col_start, col_start_next;
  logic [15:0] col_end, col_end_next;
  logic [15:0] row_first, row_first_next;
  logic [15:0] row_last, row_last_next;

  logic [2:0]  need;
  logic [15:0] col_inc;
  logic [15:0] row_inc;
  logic        little;

  assign need   = args_needed(current_command);
  assign col_inc = cur_column + 16'd1;
  assign row_inc = cur_row + 16'd1;
  assign little  = ram_control_reg[RAMCTL_LITTLE_POS];

  // Decode of one word and next-state computation
  always_comb begin
    current_command_next    = current_command;
    arg_bytes_next          = arg_bytes;
    arg_count_seen_next     = arg_count_seen;
    pixel_phase_next        = pixel_phase;
    access_control_reg_next = access_control_reg;
    color_format_reg_next   = color_format_reg;
    ram_control_reg_next    = ram_control_reg;
    display_on_flag_next    = display_on_flag;
    sleep_flag_next         = sleep_flag;
    invert_flag_next        = invert_flag;
    cur_column_next         = cur_column;
    cur_row_next            = cur_row;
    col_start_next          = col_start;
    col_end_next            = col_end;
    row_first_next          = row_first;
    row_last_next           = row_last;
    result                  = '0;

    if (!item.is_data) begin
      current_command_next = item.data_byte;
      arg_count_seen_next  = 3'd0;
      pixel_phase_next     = 1'b0;
      unique case (item.data_byte)
        OP_SOFT_RESET: begin
          current_command_next    = 8'd0;
          arg_bytes_next          = '{default: 8'd0};
          access_control_reg_next = 8'd0;
          color_format_reg_next   = COLOR_FORMAT_RST;
          ram_control_reg_next    = RAM_CTL_RST;
          display_on_flag_next    = 1'b0;
          sleep_flag_next         = 1'b1;
          invert_flag_next        = 1'b0;
          cur_column_next         = 16'd0;
          cur_row_next            = 16'd0;
          col_start_next          = 16'd0;
          col_end_next            = COL_END_RST;
          row_first_next          = 16'd0;
          row_last_next           = ROW_LAST_RST;
          result.clear_frame      = 1'b1;
        end
        OP_SLEEP_IN:    sleep_flag_next      = 1'b1;
        OP_SLEEP_OUT:   sleep_flag_next      = 1'b0;
        OP_INVERT_OFF:  invert_flag_next     = 1'b0;
        OP_INVERT_ON:   invert_flag_next     = 1'b1;
        OP_DISPLAY_OFF: display_on_flag_next = 1'b0;
        OP_DISPLAY_ON:  display_on_flag_next = 1'b1;
        default: ;
      endcase
    end else if (current_command == OP_MEMORY_WRITE) begin
      // Pixel assembly, only in 16-bit format
      if ((color_format_reg & FORMAT_MASK) == FORMAT_16BIT) begin
        if (!pixel_phase) begin
          arg_bytes_next[0] = item.data_byte;
          pixel_phase_next  = 1'b1;
        end else begin
          pixel_phase_next = 1'b0;
          if (cur_column < PANEL_W16 && cur_row < PANEL_H16) begin
            result.pixel_write = 1'b1;
            result.pixel_row   = cur_row[7:0];
            result.pixel_col   = cur_column[8:0];
            result.pixel_value = little ? {item.data_byte, arg_bytes[0]}
                                        : {arg_bytes[0], item.data_byte};
          end
          // Advance and wrap within the window
          if (col_inc > col_end) begin
            cur_column_next = col_start;
            cur_row_next    = (row_inc > row_last) ? row_first : row_inc;
          end else begin
            cur_column_next = col_inc;
          end
        end
      end
    end else if (arg_count_seen < need) begin
      // Argument collection; apply once the last byte arrives
      arg_bytes_next[arg_count_seen[1:0]] = item.data_byte;
      arg_count_seen_next = arg_count_seen + 3'd1;
      if (arg_count_seen_next == need) begin
        case (current_command)
          OP_COLUMN_SET: begin
            col_start_next  = {arg_bytes_next[0], arg_bytes_next[1]};
            col_end_next    = {arg_bytes_next[2], arg_bytes_next[3]};
            cur_column_next = {arg_bytes_next[0], arg_bytes_next[1]};
          end
          OP_ROW_SET: begin
            row_first_next = {arg_bytes_next[0], arg_bytes_next[1]};
            row_last_next  = {arg_bytes_next[2], arg_bytes_next[3]};
            cur_row_next   = {arg_bytes_next[0], arg_bytes_next[1]};
          end
          OP_ACCESS_CTL:   access_control_reg_next = arg_bytes_next[0];
          OP_PIXEL_FORMAT: color_format_reg_next   = arg_bytes_next[0];
          OP_RAM_CTL:      ram_control_reg_next    = arg_bytes_next[1];
          default: ;
        endcase
      end
    end

    // Status reflects the state after this word
    result.display_enabled = display_on_flag_next;
    result.sleep_mode      = sleep_flag_next;
    result.invert_mode     = invert_flag_next;
    result.mem_access_ctl  = access_control_reg_next;
    result.color_mode      = color_format_reg_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_command    <= 8'd0;
      arg_bytes          <= '{default: 8'd0};
      arg_count_seen     <= 3'd0;
      pixel_phase        <= 1'b0;
      access_control_reg <= 8'd0;
      color_format_reg   <= COLOR_FORMAT_RST;
      ram_control_reg    <= RAM_CTL_RST;
      display_on_flag    <= 1'b0;
      sleep_flag         <= 1'b1;
      invert_flag        <= 1'b0;
      cur_column         <= 16'd0;
      cur_row            <= 16'd0;
      col_start          <= 16'd0;
      col_end            <= COL_END_RST;
      row_first          <= 16'd0;
      row_last           <= ROW_LAST_RST;
    end else if (step) begin
      current_command    <= current_command_next;
      arg_bytes          <= arg_bytes_next;
      arg_count_seen     <= arg_count_seen_next;
      pixel_phase        <= pixel_phase_next;
      access_control_reg <= access_control_reg_next;
      color_format_reg   <= color_format_reg_next;
      ram_control_reg    <= ram_control_reg_next;
      display_on_flag    <= display_on_flag_next;
      sleep_flag         <= sleep_flag_next;
      invert_flag        <= invert_flag_next;
      cur_column         <= cur_column_next;
      cur_row            <= cur_row_next;
      col_start          <= col_start_next;
      col_end            <= col_end_next;
      row_first          <= row_first_next;
      row_last           <= row_last_next;
    end
  end

  // Checks
  a_write_needs_ramwr: assert property (@(posedge clk) disable iff (rst)
    (step && result.pixel_write) |->
      (current_command == OP_MEMORY_WRITE && pixel_phase && item.is_data))
    else $error("pixel write outside RAM write second byte");

  a_soft_reset_state: assert property (@(posedge clk) disable iff (rst)
    (step && result.clear_frame) |=>
      (current_command == 8'd0 && sleep_flag && !display_on_flag &&
       col_end == COL_END_RST && row_last == ROW_LAST_RST))
    else $error("soft reset did not restore state");

  a_arg_count_bound: assert property (@(posedge clk) disable iff (rst)
    arg_count_seen <= 3'd4)
    else $error("argument count overflow");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(cur_column) && $stable(cur_row) && $stable(current_command)))
    else $error("state changed without a word");

endmodule
`default_nettype wire

// File: design/lscw_out_stage.sv
`default_nettype none
module lscw_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                d_valid,
  output      logic                d_free,
  input  wire lscw_pkg::out_item_t d_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      lscw_pkg::out_item_t out_data
);
  import lscw_pkg::*;

  // Result register; loads when empty or being taken
  assign d_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_free) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && d_free) begin
      out_data <= d_data;
    end
  end

endmodule
`default_nettype wire

// File: design/lcd_spi_command_window_writer_core.sv
// Command and pixel-window front end of a serial LCD controller.
// din: one word per serial byte, with is_data (data/command line level) and
//   data_byte. Command words select the current command; data words carry
//   arguments or, under RAM write in 16-bit format, pixel byte pairs.
// dout: exactly one word per input word, carrying an optional pixel write
//   (row, column, value), the software-reset frame-clear request and the
//   current display, sleep, invert, access control and color format state.
// Path: an input register, then the decode and state update into the result
//   register, between acceptance on din and the result on dout.
// Throughput: one word per cycle while dout accepts; the input register, the
//   state update and the result register each move one word per clock.
// Reset (rst, synchronous): both stages empty, display off, sleeping, window
//   set to the full 320 x 240 panel, 16-bit color format.
// When dout stalls, the result register holds its word, the input register
//   keeps one more word, and din.ready drops until dout drains.
`default_nettype none
module lcd_spi_command_window_writer_core (
  input wire logic  clk,
  input wire logic  rst,
  lscw_in_if.sink   din,
  lscw_out_if.source dout
);
  import lscw_pkg::*;

  logic      q_valid;
  in_item_t  q_data;
  logic      slot_free;
  logic      step;
  out_item_t result;

  assign step = q_valid && slot_free;

  lscw_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .in_data  (din.data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_take   (step)
  );

  lscw_cmd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (q_data),
    .result (result)
  );

  lscw_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .d_valid   (q_valid),
    .d_free    (slot_free),
    .d_data    (result),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_data  (dout.data)
  );

endmodule
`default_nettype wire
